// ===== rtl/midpoint_subdivision_line_clipper_defines.svh =====
// assertion macros used by the controller of the line clipper rtl
// no dependencies; taken in by `include inside module bodies
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIPPER_DEFINES_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIPPER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define MSLC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define MSLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mslc_pkg.sv =====
// types and constants of the midpoint subdivision line clipper
// no dependencies; imported by every module of the block but mslc_ram
`timescale 1ns / 1ps

package mslc_pkg;

   localparam int COORD_BITS = 12;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // outcode bits
   localparam logic [3:0] CODE_LEFT   = 4'b0001;
   localparam logic [3:0] CODE_RIGHT  = 4'b0010;
   localparam logic [3:0] CODE_BOTTOM = 4'b0100;
   localparam logic [3:0] CODE_TOP    = 4'b1000;

   localparam coord_type WINDOW_LOW_RESET  = coord_type'(0);
   localparam coord_type WINDOW_HIGH_RESET = coord_type'(2047);

   typedef enum logic [1:0] {
      CSR_LEFT   = 2'd0,
      CSR_RIGHT  = 2'd1,
      CSR_TOP    = 2'd2,
      CSR_BOTTOM = 2'd3
   } csr_index_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type piece_x1;
      coord_type piece_y1;
      coord_type piece_x2;
      coord_type piece_y2;
      logic      piece_valid;
      logic      last;
      logic      overflow;
   } rsp_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
   } seg_type;

   localparam int SEG_BITS = $bits(seg_type);

   // controller to datapath
   typedef struct packed {
      logic load_in;    // piece register takes the new segment
      logic load_ram;   // piece register takes the popped stack entry
      logic split;      // push second half, keep first half
      logic rd_en;      // stack read
      logic emit;       // present piece as a visible result
      logic finish;     // present the closing result
      logic ovf;        // overflow flag for the closing result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic both_in;    // both endpoints inside the window
      logic drop;       // shared outcode bit or too short to split
   } status_type;

endpackage

// ===== rtl/mslc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mslc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mslc_datapath.sv =====
// datapath: window registers, piece register, outcode test, midpoint split,
// segment stack and result register; depends on mslc_pkg and mslc_ram
`timescale 1ns / 1ps

module mslc_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  mslc_pkg::csr_index_type        csr_index,
   input  mslc_pkg::coord_type            csr_wdata,
   input  mslc_pkg::req_type              req_data,
   input  mslc_pkg::cmd_type              cmd,
   input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   output mslc_pkg::status_type           status,
   output logic                           rsp_strobe,
   output mslc_pkg::rsp_type              rsp_data
);
   import mslc_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = COORD_BITS + 1;

   coord_type  window_left_ff, window_right_ff, window_top_ff, window_bottom_ff;
   seg_type    piece_ff, piece_in;
   seg_type    half_b;
   logic [SEG_BITS-1:0] ram_rd_data;
   logic       rsp_strobe_ff, rsp_strobe_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [3:0] code1, code2;
   logic [DW-1:0] dx, dy;
   logic       short_piece;
   coord_type  mx, my;

   function automatic logic [3:0] outcode(input coord_type x, input coord_type y,
                                          input coord_type l, input coord_type r,
                                          input coord_type t, input coord_type b);
      logic [3:0] c;
      c = 4'b0000;
      if (x < l) c = c | CODE_LEFT;
      if (x > r) c = c | CODE_RIGHT;
      if (y > b) c = c | CODE_BOTTOM;
      if (y < t) c = c | CODE_TOP;
      return c;
   endfunction

   // (a + b) / 2 rounded toward zero
   function automatic coord_type midpoint(input coord_type a, input coord_type b);
      logic signed [DW-1:0] s;
      logic signed [DW-1:0] h;
      s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      h = (s >>> 1) + $signed({{COORD_BITS{1'b0}}, s[DW-1] & s[0]});
      return h[COORD_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff   <= WINDOW_LOW_RESET;
         window_right_ff  <= WINDOW_HIGH_RESET;
         window_top_ff    <= WINDOW_LOW_RESET;
         window_bottom_ff <= WINDOW_HIGH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEFT:   window_left_ff   <= csr_wdata;
            CSR_RIGHT:  window_right_ff  <= csr_wdata;
            CSR_TOP:    window_top_ff    <= csr_wdata;
            CSR_BOTTOM: window_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign code1 = outcode(piece_ff.x1, piece_ff.y1, window_left_ff, window_right_ff,
                          window_top_ff, window_bottom_ff);
   assign code2 = outcode(piece_ff.x2, piece_ff.y2, window_left_ff, window_right_ff,
                          window_top_ff, window_bottom_ff);

   assign dx = {piece_ff.x1[COORD_BITS-1], piece_ff.x1}
             - {piece_ff.x2[COORD_BITS-1], piece_ff.x2};
   assign dy = {piece_ff.y1[COORD_BITS-1], piece_ff.y1}
             - {piece_ff.y2[COORD_BITS-1], piece_ff.y2};
   assign short_piece = (dx == DW'(0) || dx == DW'(1) || dx == {DW{1'b1}})
                     && (dy == DW'(0) || dy == DW'(1) || dy == {DW{1'b1}});

   assign status.both_in = (code1 == 4'b0000) && (code2 == 4'b0000);
   assign status.drop    = ((code1 & code2) != 4'b0000) || short_piece;

   assign mx = midpoint(piece_ff.x1, piece_ff.x2);
   assign my = midpoint(piece_ff.y1, piece_ff.y2);

   always_comb begin
      half_b.x1 = mx;
      half_b.y1 = my;
      half_b.x2 = piece_ff.x2;
      half_b.y2 = piece_ff.y2;
      piece_in  = piece_ff;
      if (cmd.load_in) begin
         piece_in.x1 = req_data.start_x;
         piece_in.y1 = req_data.start_y;
         piece_in.x2 = req_data.end_x;
         piece_in.y2 = req_data.end_y;
      end else if (cmd.load_ram) begin
         piece_in = seg_type'(ram_rd_data);
      end else if (cmd.split) begin
         piece_in.x2 = mx;
         piece_in.y2 = my;
      end
   end

   always_ff @(posedge clock) begin
      piece_ff <= piece_in;
   end

   mslc_ram #(
      .WIDTH (SEG_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.split),
      .wr_addr (wr_addr[AW-1:0]),
      .wr_data (SEG_BITS'(half_b)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_strobe_in = cmd.emit | cmd.finish;
      rsp_data_in   = '0;
      if (cmd.emit) begin
         rsp_data_in.piece_x1    = piece_ff.x1;
         rsp_data_in.piece_y1    = piece_ff.y1;
         rsp_data_in.piece_x2    = piece_ff.x2;
         rsp_data_in.piece_y2    = piece_ff.y2;
         rsp_data_in.piece_valid = 1'b1;
      end else if (cmd.finish) begin
         rsp_data_in.last     = 1'b1;
         rsp_data_in.overflow = cmd.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/mslc_ctrl.sv =====
// controller: sequencing state machine, stack pointer, piece count, overflow
// depends on mslc_pkg and the assertion macro header
`timescale 1ns / 1ps

module mslc_ctrl #(
   parameter int STACK_DEPTH = 16,
   parameter int MAX_PIECES  = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mslc_pkg::status_type           status,
   output mslc_pkg::cmd_type              cmd,
   output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   output logic [$clog2(STACK_DEPTH)-1:0] rd_addr
);
   import mslc_pkg::*;
   `include "midpoint_subdivision_line_clipper_defines.svh"

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int CW  = $clog2(MAX_PIECES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_POP,
      ST_LOAD,
      ST_CLOSE
   } state_type;

   state_type      state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [SPW:0]   sp_plus2;
   logic [SPW-1:0] sp_minus1;
   logic           full;
   state_type      after_piece;

   assign sp_plus2  = {1'b0, sp_ff} + (SPW + 1)'(2);
   assign sp_minus1 = sp_ff - SPW'(1);
   assign full      = sp_plus2 > (SPW + 1)'(STACK_DEPTH);
   assign after_piece = (sp_ff == '0) ? ST_CLOSE : ST_POP;

   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      cmd      = '0;
      cmd.ovf  = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_in = 1'b1;
               sp_in       = '0;
               count_in    = '0;
               ovf_in      = 1'b0;
               state_in    = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.both_in) begin
               if (count_ff < CW'(MAX_PIECES)) begin
                  cmd.emit = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = after_piece;
            end else if (status.drop) begin
               state_in = after_piece;
            end else if (full) begin
               ovf_in   = 1'b1;
               state_in = after_piece;
            end else begin
               // second half goes on the stack, first half stays for the next test
               cmd.split = 1'b1;
               sp_in     = sp_ff + SPW'(1);
            end
         end
         ST_POP: begin
            cmd.rd_en = 1'b1;
            sp_in     = sp_minus1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_ram = 1'b1;
            state_in     = ST_TEST;
         end
         ST_CLOSE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign wr_addr = sp_ff[AW-1:0];
   assign rd_addr = sp_minus1[AW-1:0];

   `MSLC_ASSERT_NOW(a_sp_room, 1'b1, sp_ff < SPW'(STACK_DEPTH), "stack pointer past depth")
   `MSLC_ASSERT_NOW(a_pop_nonempty, state_ff == ST_POP, sp_ff != '0, "pop from empty stack")
   `MSLC_ASSERT_NOW(a_close_empty, cmd.finish, sp_ff == '0, "closing with pieces pending")
   `MSLC_ASSERT_NEXT(a_emit_limit, cmd.emit, count_ff <= CW'(MAX_PIECES), "piece count past limit")
   `MSLC_ASSERT_NOW(a_one_result, 1'b1, !(cmd.emit && cmd.finish), "two results in one cycle")

endmodule

// ===== rtl/midpoint_subdivision_line_clipper.sv =====
// start loads the segment into the piece register for its first test; every result is registered,
//   and a new segment is taken only once the closing state is done and the block is idle again
// each popped piece needs a stack read with registered data (pop, load, test)
// reset: synchronous, active high; clears the sequencer and resets the window to 0..2047
// the segment stack is not cleared; every entry is written before it is read
// results are one-cycle strobes, the receiver cannot stall
`timescale 1ns / 1ps

module midpoint_subdivision_line_clipper #(
   parameter int STACK_DEPTH = 16,
   parameter int MAX_PIECES  = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   // input item: one segment, taken on start while not busy
   input  logic                    start,
   output logic                    busy,
   input  mslc_pkg::req_type       req_data,
   // result items: visible pieces, then one closing item with last set
   output logic                    rsp_strobe,
   output mslc_pkg::rsp_type       rsp_data,
   // window registers
   input  logic                    csr_wr_en,
   input  mslc_pkg::csr_index_type csr_index,
   input  mslc_pkg::coord_type     csr_wdata
);
   import mslc_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   // sequencer: decides emit, drop or split for the piece under test and
   // walks the stack of pending halves
   mslc_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_PIECES  (MAX_PIECES)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .status  (status),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   // datapath: window and piece registers, outcodes, midpoint, stack memory and result register
   mslc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_data   (req_data),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== bench/clip_result_checker.sv =====
// result checker for the midpoint subdivision line clipper: mirrors the window
// registers, predicts the pieces of every accepted segment and compares results
// depends on mslc_pkg
`timescale 1ns / 1ps

module clip_result_checker #(
   parameter int STACK_DEPTH = 16,
   parameter int MAX_PIECES  = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  mslc_pkg::req_type       req_data,
   input  logic                    rsp_strobe,
   input  mslc_pkg::rsp_type       rsp_data,
   input  logic                    csr_wr_en,
   input  mslc_pkg::csr_index_type csr_index,
   input  mslc_pkg::coord_type     csr_wdata,
   output int                      fail_count,
   output int                      expected_left,
   output int                      segments_taken,
   output int                      pieces_seen,
   output int                      overflow_seen
);
   import mslc_pkg::*;

   typedef struct {
      int x1;
      int y1;
      int x2;
      int y2;
   } span_type;

   int      win_left, win_right, win_top, win_bottom;
   int      result_count;
   rsp_type pieces_due[$];

   function automatic logic [3:0] region_code(int x, int y);
      logic [3:0] code;
      code = '0;
      if (x < win_left)   code |= CODE_LEFT;
      if (x > win_right)  code |= CODE_RIGHT;
      if (y > win_bottom) code |= CODE_BOTTOM;
      if (y < win_top)    code |= CODE_TOP;
      return code;
   endfunction

   function automatic int span_of(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // explicit stack, first half popped before second half
   function automatic void clip_segment(req_type seg);
      span_type   pending[STACK_DEPTH];
      span_type   cur, head, tail;
      int         depth, emitted, mx, my;
      logic [3:0] c1, c2;
      logic       dropped_any;
      rsp_type    piece;
      depth       = 0;
      emitted     = 0;
      dropped_any = 1'b0;
      pending[0]  = '{int'(seg.start_x), int'(seg.start_y), int'(seg.end_x), int'(seg.end_y)};
      depth       = 1;
      while (depth > 0) begin
         depth--;
         cur = pending[depth];
         c1  = region_code(cur.x1, cur.y1);
         c2  = region_code(cur.x2, cur.y2);
         if (c1 == '0 && c2 == '0) begin
            if (emitted < MAX_PIECES) begin
               piece = '0;
               piece.piece_x1    = coord_type'(cur.x1);
               piece.piece_y1    = coord_type'(cur.y1);
               piece.piece_x2    = coord_type'(cur.x2);
               piece.piece_y2    = coord_type'(cur.y2);
               piece.piece_valid = 1'b1;
               pieces_due.push_back(piece);
               emitted++;
            end else begin
               dropped_any = 1'b1;
            end
         end else if ((c1 & c2) != '0) begin
            // trivially outside
         end else if (span_of(cur.x1, cur.x2) <= 1 && span_of(cur.y1, cur.y2) <= 1) begin
            // too short to split any further
         end else if (depth + 2 > STACK_DEPTH) begin
            dropped_any = 1'b1;
         end else begin
            // int division truncates toward zero
            mx = (cur.x1 + cur.x2) / 2;
            my = (cur.y1 + cur.y2) / 2;
            head = '{cur.x1, cur.y1, mx, my};
            tail = '{mx, my, cur.x2, cur.y2};
            pending[depth]     = tail;
            pending[depth + 1] = head;
            depth += 2;
         end
      end
      piece = '0;
      piece.last     = 1'b1;
      piece.overflow = dropped_any;
      pieces_due.push_back(piece);
   endfunction

   task automatic report_field(string name, logic [COORD_BITS-1:0] want,
                               logic [COORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t result %0d: %s expected %0d, got %0d", $time, result_count, name,
                  $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         win_left   = int'(WINDOW_LOW_RESET);
         win_right  = int'(WINDOW_HIGH_RESET);
         win_top    = int'(WINDOW_LOW_RESET);
         win_bottom = int'(WINDOW_HIGH_RESET);
         pieces_due.delete();
         fail_count     = 0;
         result_count   = 0;
         segments_taken = 0;
         pieces_seen    = 0;
         overflow_seen  = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEFT:   win_left   = int'(csr_wdata);
               CSR_RIGHT:  win_right  = int'(csr_wdata);
               CSR_TOP:    win_top    = int'(csr_wdata);
               CSR_BOTTOM: win_bottom = int'(csr_wdata);
               default: ;
            endcase
         end
         if (start && !busy) begin
            clip_segment(req_data);
            segments_taken++;
         end
         if (rsp_strobe) begin
            if (pieces_due.size() == 0) begin
               $display("%0t result %0d: expected none, got %p", $time, result_count, rsp_data);
               fail_count++;
            end else begin
               want = pieces_due.pop_front();
               report_field("piece_x1", want.piece_x1, rsp_data.piece_x1);
               report_field("piece_y1", want.piece_y1, rsp_data.piece_y1);
               report_field("piece_x2", want.piece_x2, rsp_data.piece_x2);
               report_field("piece_y2", want.piece_y2, rsp_data.piece_y2);
               report_field("piece_valid", COORD_BITS'(want.piece_valid),
                            COORD_BITS'(rsp_data.piece_valid));
               report_field("last", COORD_BITS'(want.last), COORD_BITS'(rsp_data.last));
               report_field("overflow", COORD_BITS'(want.overflow),
                            COORD_BITS'(rsp_data.overflow));
               if (want.piece_valid) pieces_seen++;
               if (want.last && want.overflow) overflow_seen++;
            end
            result_count++;
         end
      end
      expected_left = pieces_due.size();
   end

endmodule

// ===== bench/midpoint_subdivision_line_clipper_tb.sv =====
// top level bench of the midpoint subdivision line clipper: drives segments and
// window settings, gives the verdict; checking lives in clip_result_checker
// depends on mslc_pkg, clip_result_checker and the clipper rtl
`timescale 1ns / 1ps

module midpoint_subdivision_line_clipper_tb;
   import mslc_pkg::*;

   localparam int RUN_LIMIT   = 3_000_000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 46;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_data;
   logic          rsp_strobe;
   rsp_type       rsp_data;
   logic          csr_wr_en;
   csr_index_type csr_index;
   coord_type     csr_wdata;

   int fail_count, expected_left, segments_taken, pieces_seen, overflow_seen;

   // our copy of the window, used only to aim segments at its edges
   int win_left, win_right, win_top, win_bottom;
   int burst_left;
   int settings_used;
   int cycle_count = 0;

   midpoint_subdivision_line_clipper u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   clip_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .expected_left  (expected_left),
      .segments_taken (segments_taken),
      .pieces_seen    (pieces_seen),
      .overflow_seen  (overflow_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                  expected_left);
         $display("FAIL midpoint_subdivision_line_clipper");
         $finish;
      end
   end

   // clamp into the coordinate range
   function automatic coord_type fit(int v);
      if (v < -2048) return coord_type'(-2048);
      if (v > 2047)  return coord_type'(2047);
      return coord_type'(v);
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // a coordinate on or close to one of two window edges, between them give or take 50, or anywhere
   function automatic coord_type pick_near(int lo, int hi);
      int a, b;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 3))
         0:       return fit(lo + int'($urandom_range(0, 4)) - 2);
         1:       return fit(hi + int'($urandom_range(0, 4)) - 2);
         2:       return fit(a - 50 + int'($urandom_range(0, b - a + 100)));
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type pick_within(int lo, int hi);
      if (lo <= hi) return fit(lo + int'($urandom_range(0, hi - lo)));
      return pick_near(lo, hi);
   endfunction

   // start stays high across back to back items inside a burst; a gap
   // lowers it for a random number of cycles before the next burst
   task automatic send_segment(coord_type x1, coord_type y1, coord_type x2, coord_type y2);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= '{start_x: x1, start_y: y1, end_x: x2, end_y: y2};
      // busy only moves on the rising edge, so its value now holds for the next edge
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // stop sending until every expected result is back and the block is idle
   task automatic wait_idle();
      start <= 1'b0;
      burst_left = 0;
      while (expected_left != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= coord_type'(v);
      @(negedge clock);
   endtask

   task automatic write_window(int l, int r, int t, int b);
      wait_idle();
      write_register(CSR_LEFT, l);
      write_register(CSR_RIGHT, r);
      write_register(CSR_TOP, t);
      write_register(CSR_BOTTOM, b);
      csr_wr_en <= 1'b0;
      win_left   = l;
      win_right  = r;
      win_top    = t;
      win_bottom = b;
      settings_used++;
   endtask

   // window of each random phase: full range, small, single point, empty,
   // corner point, arbitrary, ordered random, back to the reset window
   task automatic choose_window(int phase);
      int a, b, c, d, half;
      a = rand_coord();
      b = rand_coord();
      c = rand_coord();
      d = rand_coord();
      case (phase)
         0: write_window(-2048, 2047, -2048, 2047);
         1: begin
            half = $urandom_range(0, 40);
            write_window(int'(fit(a - half)), int'(fit(a + half)),
                         int'(fit(c - half)), int'(fit(c + half)));
         end
         2: write_window(a, a, c, c);
         3: begin
            // left above right and top below bottom: nothing is inside
            a = int'($urandom_range(0, 1500));
            c = int'($urandom_range(0, 1500)) - 1000;
            write_window(a, a - 1 - int'($urandom_range(0, 300)),
                         c, c - 1 - int'($urandom_range(0, 300)));
         end
         4: write_window(2047, 2047, -2048, -2048);
         5: write_window(a, b, c, d);
         6: write_window((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c);
         default: write_window(0, 2047, 0, 2047);
      endcase
   endtask

   // mostly segments that touch or cross the window edges, since those are
   // the ones that get subdivided; the rest is full range noise or segments inside the window
   task automatic random_segment();
      coord_type x1, y1, x2, y2, swap;
      case ($urandom_range(0, 9))
         0, 1: begin
            x1 = coord_type'($urandom);
            y1 = coord_type'($urandom);
            x2 = coord_type'($urandom);
            y2 = coord_type'($urandom);
         end
         2, 3, 4, 5: begin
            x1 = pick_near(win_left, win_right);
            y1 = pick_near(win_top, win_bottom);
            x2 = pick_near(win_left, win_right);
            y2 = pick_near(win_top, win_bottom);
         end
         6: begin
            x1 = pick_within(win_left, win_right);
            y1 = pick_within(win_top, win_bottom);
            x2 = pick_within(win_left, win_right);
            y2 = pick_within(win_top, win_bottom);
         end
         7: begin
            // very short pieces around the edges
            x1 = pick_near(win_left, win_right);
            y1 = pick_near(win_top, win_bottom);
            x2 = fit(int'(x1) + int'($urandom_range(0, 4)) - 2);
            y2 = fit(int'(y1) + int'($urandom_range(0, 4)) - 2);
         end
         8: begin
            // both ends left of the window
            x1 = fit(win_left - 1 - int'($urandom_range(0, 300)));
            x2 = fit(win_left - 1 - int'($urandom_range(0, 300)));
            y1 = coord_type'($urandom);
            y2 = coord_type'($urandom);
         end
         default: begin
            // full width line skimming a horizontal edge
            x1 = coord_type'(-2048);
            x2 = coord_type'(2047);
            y1 = pick_near(win_top, win_bottom);
            y2 = fit(int'(y1) + int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1) == 1) begin
               swap = x1; x1 = x2; x2 = swap;
            end
         end
      endcase
      send_segment(x1, y1, x2, y2);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_LEFT;
      csr_wdata     = '0;
      win_left      = int'(WINDOW_LOW_RESET);
      win_right     = int'(WINDOW_HIGH_RESET);
      win_top       = int'(WINDOW_LOW_RESET);
      win_bottom    = int'(WINDOW_HIGH_RESET);
      burst_left    = 0;
      settings_used = 1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset window 0..2047 in both axes
      send_segment(0, 0, 0, 0);                   // point on the corner
      send_segment(2047, 2047, 2047, 2047);       // point on the far corner
      send_segment(-2048, -2048, 2047, 2047);     // full diagonal, enters at a corner
      send_segment(2047, -2048, -2048, 2047);     // anti diagonal, misses the window
      send_segment(-2048, -2048, -2048, -2048);   // point outside
      send_segment(-10, 5, -1, 900);              // both ends left, trivially out
      send_segment(-1, -1, 0, 0);                 // one unit long, not inside
      send_segment(-1, 100, 1, 100);              // one split, half inside
      send_segment(-2048, 1000, 2047, 1000);      // horizontal through the left edge
      send_segment(1000, -2048, 1000, 2047);      // vertical through the top edge
      send_segment(100, 200, 1500, 1800);         // wholly inside
      send_segment(2047, 0, -2048, -1);           // odd negative sums truncate toward zero
      send_segment(-3, -2048, 2047, -3);

      // small window around the origin: deep subdivision
      write_window(-5, 5, -5, 5);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(-2048, 2047, 2047, -2048);
      send_segment(-2048, 0, 2047, 1);
      send_segment(-7, -6, 7, 6);
      send_segment(-2047, -3, -1, 3);

      // single point window
      write_window(0, 0, 0, 0);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(-1, 0, 1, 0);

      // inverted window, only the closing item may come back
      write_window(5, -5, 5, -5);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(0, 0, 0, 0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         choose_window(phase);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then let everything drain before going on
            if ($urandom_range(0, 39) == 0) wait_idle();
            random_segment();
         end
      end

      start <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      // room for any stray result after the last closing item
      repeat (40) @(negedge clock);

      $display("run covered %0d segments under %0d window settings", segments_taken,
               settings_used);
      $display("%0d visible pieces checked, %0d segments closed with overflow", pieces_seen,
               overflow_seen);
      if (fail_count == 0) begin
         $display("PASS midpoint_subdivision_line_clipper");
      end else begin
         $display("FAIL midpoint_subdivision_line_clipper");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mslc_pkg.sv
rtl/mslc_ram.sv
rtl/mslc_datapath.sv
rtl/mslc_ctrl.sv
rtl/midpoint_subdivision_line_clipper.sv
bench/clip_result_checker.sv
bench/midpoint_subdivision_line_clipper_tb.sv
